[rtl/i2c_master_bit_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// i2c master bit sequencer assertion macros
// concurrent checks on clk_i, held off during reset
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTH
`define I2CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define I2CBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define I2CBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CBS_ASSERT(lbl, prop, msg)
`define I2CBS_ASSERT_IMP(lbl, ante, cons, msg)
`define I2CBS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/i2cbs_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbs_pkg
// types and codes shared by the i2c master bit sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

  typedef enum logic [3:0] {
    CMD_IDLE    = 4'd0,
    CMD_START   = 4'd1,
    CMD_STOP    = 4'd2,
    CMD_SEND    = 4'd3,
    CMD_WACK    = 4'd4,
    CMD_READ    = 4'd5,
    CMD_ACK     = 4'd6,
    CMD_NACK    = 4'd7,
    CMD_RECOVER = 4'd8
  } cmd_e;

  localparam int unsigned InBits  = 13;
  localparam int unsigned OutBits = 14;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // last tick of a send byte and of a read byte, last sub tick of a send bit
  localparam logic [4:0] SendLastPh = 5'd23;
  localparam logic [4:0] ReadLastPh = 5'd15;
  localparam logic [1:0] SubLast    = 2'd2;

  typedef struct packed {
    logic       sda_in;
    logic [7:0] tx_byte;
    logic [3:0] req_type;
  } req_t;

  typedef struct packed {
    logic       bus_released;
    logic       ack_level;
    logic [7:0] rx_byte;
    logic       cmd_done;
    logic       engine_busy;
    logic       sda_drive;
    logic       scl_drive;
  } res_t;

endpackage

`default_nettype wire

[rtl/i2cbs_in_stage.sv]
// ----------------------------------------------------------------------------
// i2cbs_in_stage
// input register of the bit sequencer, holds one tick request
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire i2cbs_pkg::req_t req_i,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output i2cbs_pkg::req_t      req_o
);
  import i2cbs_pkg::*;

  logic vld_q, vld_d;
  req_t req_q;
  logic load;

  assign ready_o = !vld_q || pop_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (pop_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = vld_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

[rtl/i2cbs_engine.sv]
// ----------------------------------------------------------------------------
// i2cbs_engine
// bit engine state and one-tick next-state logic for scl/sda sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_engine #(
  parameter int unsigned RECOVER_PULSES = 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire i2cbs_pkg::req_t req_i,
  output i2cbs_pkg::res_t      res_o
);
  import i2cbs_pkg::*;

  localparam logic [3:0] PulseMax = 4'(RECOVER_PULSES);

  cmd_e       cmd_q, cmd_d, cmd;
  logic [4:0] ph_q, ph_d, p, nxt;
  logic [1:0] sub_q, sub_d, sub;
  logic [7:0] sh_q, sh_d, sh;
  logic       scl_q, scl_d, sda_q, sda_d;
  logic       ack_q, ack_d;
  logic [3:0] pc_q, pc_d, pc, pc_inc;
  logic       rel_q, rel_d, rel;
  logic       take, scl, sda, done, rel_after;
  logic [7:0] rx;

  always_comb begin
    take = (cmd_q == CMD_IDLE) && (req_i.req_type >= 4'(CMD_START))
        && (req_i.req_type <= 4'(CMD_RECOVER));
    cmd  = take ? cmd_e'(req_i.req_type) : cmd_q;
    p    = take ? 5'd0 : ph_q;
    sub  = take ? 2'd0 : sub_q;
    sh   = sh_q;
    pc   = pc_q;
    rel  = rel_q;
    if (take) begin
      if (cmd == CMD_SEND) sh = req_i.tx_byte;
      if (cmd == CMD_READ) sh = 8'd0;
      if (cmd == CMD_RECOVER) begin
        pc  = 4'd0;
        rel = 1'b0;
      end
    end
    pc_inc = pc + 4'd1;

    scl       = scl_q;
    sda       = sda_q;
    done      = 1'b0;
    rx        = 8'd0;
    rel_after = 1'b0;
    nxt       = p + 5'd1;
    sh_d      = sh;
    ack_d     = ack_q;
    pc_d      = pc;
    rel_d     = rel;
    sub_d     = 2'd0;

    unique case (cmd)
      CMD_START: begin
        scl  = (p != 5'd2);
        sda  = (p == 5'd0);
        done = (p >= 5'd2);
      end
      CMD_STOP: begin
        scl  = (p != 5'd0);
        sda  = (p == 5'd2);
        done = (p >= 5'd2);
      end
      CMD_SEND: begin
        scl   = (sub == 2'd1);
        sda   = sh[7];
        sub_d = (sub == SubLast) ? 2'd0 : sub + 2'd1;
        if (sub == SubLast) sh_d = {sh[6:0], 1'b0};
        done      = (p >= SendLastPh);
        rel_after = done;
      end
      CMD_WACK: begin
        scl = (p == 5'd1);
        sda = 1'b1;
        if (p == 5'd1) ack_d = req_i.sda_in;
        done = (p >= 5'd2);
      end
      CMD_READ: begin
        sda = sda_q;
        scl = !p[0];
        if (!p[0]) sh_d = {sh[6:0], req_i.sda_in};
        done = (p >= ReadLastPh);
        if (done) rx = sh_d;
      end
      CMD_ACK, CMD_NACK: begin
        scl       = (p == 5'd1);
        sda       = (cmd == CMD_NACK);
        done      = (p >= 5'd2);
        rel_after = done;
      end
      CMD_RECOVER: begin
        if (p == 5'd0 || p == 5'd2) begin
          scl = 1'b1;
          sda = 1'b1;
          if (p == 5'd2) pc_d = pc_inc;
          if (req_i.sda_in) begin
            rel_d = 1'b1;
            nxt   = 5'd3;
          end else if (p == 5'd2 && pc_inc >= PulseMax) begin
            nxt = 5'd3;
          end else begin
            nxt = 5'd1;
          end
        end else if (p == 5'd1) begin
          scl = 1'b0;
          sda = 1'b1;
        end else begin
          // closing stop: (0,0) (1,0) (1,1)
          scl  = (p != 5'd3);
          sda  = (p >= 5'd5);
          done = (p >= 5'd5);
        end
      end
      default: begin
      end
    endcase

    cmd_d = cmd_q;
    ph_d  = ph_q;
    scl_d = scl_q;
    sda_d = sda_q;
    if (cmd != CMD_IDLE) begin
      scl_d = scl;
      sda_d = (done && rel_after) ? 1'b1 : sda;
      cmd_d = done ? CMD_IDLE : cmd;
      ph_d  = done ? 5'd0 : nxt;
    end else begin
      sub_d = sub_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_IDLE;
      ph_q  <= 5'd0;
      sub_q <= 2'd0;
      sh_q  <= 8'd0;
      scl_q <= 1'b1;
      sda_q <= 1'b1;
      ack_q <= 1'b1;
      pc_q  <= 4'd0;
      rel_q <= 1'b0;
    end else if (en_i) begin
      cmd_q <= cmd_d;
      ph_q  <= ph_d;
      sub_q <= sub_d;
      sh_q  <= sh_d;
      scl_q <= scl_d;
      sda_q <= sda_d;
      ack_q <= ack_d;
      pc_q  <= pc_d;
      rel_q <= rel_d;
    end
  end

  always_comb begin
    res_o.scl_drive    = scl;
    res_o.sda_drive    = sda;
    res_o.engine_busy  = (cmd_d != CMD_IDLE);
    res_o.cmd_done     = done;
    res_o.rx_byte      = rx;
    res_o.ack_level    = ack_d;
    res_o.bus_released = rel_d;
  end

endmodule

`default_nettype wire

[rtl/i2c_master_bit_sequencer_core.sv]
// a request taken into the input register has its result registered in the output register when the engine fires
// throughput: one request per cycle while the result is taken, the engine steps one bit phase per request
// a waiting result stalls the engine; the input register still takes one more request if it is empty
// reset: asynchronous, active low; engine idle, scl/sda released, ack level 1
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// open-drain i2c master bit engine, one tick per stream request
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2c_master_bit_sequencer_core #(
  parameter int unsigned RECOVER_PULSES = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] req_type, [11:4] tx_byte, [12] sda_in, [15:13] zero
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl_drive, [1] sda_drive, [2] engine_busy, [3] cmd_done,
  // [11:4] rx_byte, [12] ack_level, [13] bus_released, [15:14] zero
  output logic [15:0]      m_axis_tdata
);
  import i2cbs_pkg::*;

  req_t req_in, req_s1;
  res_t res_c, res_q;
  logic in_vld, out_can, fire;
  logic o_vld_q, o_vld_d;

  assign req_in  = req_t'(s_axis_tdata[InBits-1:0]);
  assign out_can = !o_vld_q || m_axis_tready;
  assign fire    = in_vld && out_can;

  i2cbs_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .req_i   (req_in),
    .pop_i   (fire),
    .valid_o (in_vld),
    .req_o   (req_s1)
  );

  i2cbs_engine #(
    .RECOVER_PULSES (RECOVER_PULSES)
  ) u_eng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .req_i  (req_s1),
    .res_o  (res_c)
  );

  always_comb begin
    o_vld_d = o_vld_q;
    if (fire) begin
      o_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      o_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_c;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {{(OutDataW-OutBits){1'b0}}, res_q};

  `I2CBS_ASSERT_NXT(a_fire_fills_out, fire, o_vld_q, "result register not loaded")
  `I2CBS_ASSERT_IMP(a_ready_when_empty, !in_vld, s_axis_tready, "input stage empty but stalled")
  `I2CBS_ASSERT_IMP(a_done_not_busy, fire && res_c.cmd_done, !res_c.engine_busy,
                    "engine busy on done tick")
  `I2CBS_ASSERT_IMP(a_rx_only_done, fire && !res_c.cmd_done, res_c.rx_byte == 8'd0,
                    "rx byte shown without done")

endmodule

`default_nettype wire
